FILE: hdl/fde_pkg.sv
// Shared constants and types of the frame buffer draw engine.
// No dependencies; every other file but fde_store imports this package.
`default_nettype none
package fde_pkg;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_POINT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LINE   = 3'd1;
  localparam logic [OP_W-1:0] OP_CIRCLE = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd3;
  localparam logic [OP_W-1:0] OP_BINARY = 3'd4;
  localparam logic [OP_W-1:0] OP_INVERT = 3'd5;
  localparam logic [OP_W-1:0] OP_READ   = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RADIUS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RESET = 7'd64;

  // Memory access request between pipeline stages
  typedef struct packed {
    logic wr;
    logic rd;
  } px_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/fde_if.sv
// Channel interfaces of the draw engine: command, read response, config write.
// Depends on fde_pkg.
`default_nettype none
interface fde_cmd_if #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32
);
  import fde_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              op;
  logic signed [COORD_BITS-1:0] x_a;
  logic signed [COORD_BITS-1:0] y_a;
  logic signed [COORD_BITS-1:0] x_b;
  logic signed [COORD_BITS-1:0] y_b;
  logic [RADIUS_W-1:0]          radius;
  logic [PIXEL_BITS-1:0]        value;
  logic [PIXEL_BITS-1:0]        alt_value;
  modport source (output valid, op, x_a, y_a, x_b, y_b, radius, value, alt_value,
                  input ready);
  modport sink (input valid, op, x_a, y_a, x_b, y_b, radius, value, alt_value,
                output ready);
endinterface

interface fde_rsp_if #(
  parameter int PIXEL_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] read_value;
  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

interface fde_cfg_if;
  import fde_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/framebuffer_draw_engine_top.sv
// Point and read touch one pixel; line steps along its major axis, circle through its clipped
// box; fill writes all n = width*height entries, binarize and invert read and rewrite each.
// Throughput: one command at a time; the sequencer and the one store port set the
// figure, about one pixel per cycle for draws.
// Reset clears control state and sets both frame sizes to 64; the pixel store is
// not cleared and must be filled before it is read.
`default_nettype none
module framebuffer_draw_engine_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 12
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  fde_cmd_if.sink   cmd_i,
  fde_rsp_if.source rsp_o,
  fde_cfg_if.sink   cfg_i
);
  import fde_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_WIDTH + 1);
  localparam int SH    = $clog2(MAX_HEIGHT + 1);
  localparam int EW    = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
  localparam int SQW   = 2 * EW;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_POINT  = 4'd1;
  localparam logic [3:0] ST_LSET   = 4'd2;
  localparam logic [3:0] ST_LRUN   = 4'd3;
  localparam logic [3:0] ST_CS0    = 4'd4;
  localparam logic [3:0] ST_CS1    = 4'd5;
  localparam logic [3:0] ST_CS2    = 4'd6;
  localparam logic [3:0] ST_CRUN   = 4'd7;
  localparam logic [3:0] ST_SSET   = 4'd8;
  localparam logic [3:0] ST_SFILL  = 4'd9;
  localparam logic [3:0] ST_SRD    = 4'd10;
  localparam logic [3:0] ST_SWR    = 4'd11;
  localparam logic [3:0] ST_DRAIN  = 4'd12;
  localparam logic [3:0] ST_RD_OUT = 4'd13;

  logic [3:0] state_q, state_d;

  // configuration
  logic [CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;
  logic [SW-1:0]         act_w;
  logic [SH-1:0]         act_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= FRAME_SIZE_RESET;
      cfg_h_q <= FRAME_SIZE_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_FRAME_WIDTH) begin
        cfg_w_q <= cfg_i.data;
      end
      if (cfg_i.index == REG_FRAME_HEIGHT) begin
        cfg_h_q <= cfg_i.data;
      end
    end
  end
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (32'(cfg_w_q) > MAX_WIDTH) begin
      act_w = SW'(MAX_WIDTH);
    end else begin
      act_w = SW'(cfg_w_q);
    end
    if (32'(cfg_h_q) > MAX_HEIGHT) begin
      act_h = SH'(MAX_HEIGHT);
    end else begin
      act_h = SH'(cfg_h_q);
    end
  end

  // command registers
  logic [OP_W-1:0]       op_q;
  logic signed [EW-1:0]  xa_q, ya_q, xb_q, yb_q;
  logic [RADIUS_W-1:0]   rad_q;
  logic [PIXEL_BITS-1:0] val_q, alt_q;
  logic                  accept;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cmd_i.op;
      xa_q  <= EW'(cmd_i.x_a);
      ya_q  <= EW'(cmd_i.y_a);
      xb_q  <= EW'(cmd_i.x_b);
      yb_q  <= EW'(cmd_i.y_b);
      rad_q <= cmd_i.radius;
      val_q <= cmd_i.value;
      alt_q <= cmd_i.alt_value;
    end
  end

  // shared multiplier
  logic signed [EW-1:0]  mul_a, mul_b;
  logic signed [SQW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // line stepper state
  logic                 lxmaj_q, lxmaj_d, lneg_q, lneg_d;
  logic signed [EW-1:0] lcur_q, lcur_d, lend_q, lend_d, lbase_q, lbase_d;
  logic [EW-1:0]        ld_q, ld_d, lad_q, lad_d, lq_q, lq_d, lr_q, lr_d;

  // circle stepper state
  logic signed [EW-1:0]  cylo_q, cylo_d, cyhi_q, cyhi_d, cxlo_q, cxlo_d;
  logic signed [EW-1:0]  cxhi_q, cxhi_d, cx_q, cx_d, cy_q, cy_d;
  logic signed [SQW-1:0] crr_q, crr_d, csy_q, csy_d, csx_q, csx_d, csx0_q, csx0_d;

  // sweep state
  logic [NW-1:0] sn_q, sn_d;
  logic [AW-1:0] si_q, si_d;

  logic [1:0] dcnt_q, dcnt_d;

  // pixel request register
  px_ctl_t               px_ctl_q, px_ctl_d;
  logic signed [EW-1:0]  px_x_q, px_x_d, px_y_q, px_y_d;

  // output register
  logic                  ov_q, ov_d;
  logic [PIXEL_BITS-1:0] ovl_q, ovl_d;

  // store access
  px_ctl_t               pp_ctl;
  logic [AW-1:0]         pp_addr;
  logic [PIXEL_BITS-1:0] pp_data;
  logic                  pp_inb;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata;

  // line helpers
  logic signed [EW-1:0] l_dx, l_dy, l_adx, l_ady, l_sa, l_sb, l_ea, l_eb, l_dmin;
  logic                 l_xmaj, l_swap;
  logic [EW-1:0]        l_rsum;
  logic signed [EW-1:0] l_minor;
  logic signed [EW-1:0] c_r;
  logic signed [SQW-1:0] c_sum;

  always_comb begin
    state_d   = state_q;
    lxmaj_d   = lxmaj_q;
    lneg_d    = lneg_q;
    lcur_d    = lcur_q;
    lend_d    = lend_q;
    lbase_d   = lbase_q;
    ld_d      = ld_q;
    lad_d     = lad_q;
    lq_d      = lq_q;
    lr_d      = lr_q;
    cylo_d    = cylo_q;
    cyhi_d    = cyhi_q;
    cxlo_d    = cxlo_q;
    cxhi_d    = cxhi_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    crr_d     = crr_q;
    csy_d     = csy_q;
    csx_d     = csx_q;
    csx0_d    = csx0_q;
    sn_d      = sn_q;
    si_d      = si_q;
    dcnt_d    = dcnt_q;
    px_ctl_d  = '0;
    px_x_d    = px_x_q;
    px_y_d    = px_y_q;
    ov_d      = ov_q && !rsp_o.ready;
    ovl_d     = ovl_q;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = pp_ctl.wr;
    mem_re    = pp_ctl.rd;
    mem_addr  = pp_addr;
    mem_wdata = pp_data;

    l_dx   = xb_q - xa_q;
    l_dy   = yb_q - ya_q;
    l_adx  = l_dx[EW-1] ? -l_dx : l_dx;
    l_ady  = l_dy[EW-1] ? -l_dy : l_dy;
    l_xmaj = l_adx > l_ady;
    l_swap = l_xmaj ? (xa_q > xb_q) : (ya_q > yb_q);
    // major coordinate (a) and minor coordinate (b) of start and end
    l_sa   = l_xmaj ? (l_swap ? xb_q : xa_q) : (l_swap ? yb_q : ya_q);
    l_sb   = l_xmaj ? (l_swap ? yb_q : ya_q) : (l_swap ? xb_q : xa_q);
    l_ea   = l_xmaj ? (l_swap ? xa_q : xb_q) : (l_swap ? ya_q : yb_q);
    l_eb   = l_xmaj ? (l_swap ? ya_q : yb_q) : (l_swap ? xa_q : xb_q);
    l_dmin = l_eb - l_sb;
    l_rsum = lr_q + lad_q;
    l_minor = lneg_q ? (lbase_q - $signed(lq_q)) : (lbase_q + $signed(lq_q));
    c_r    = $signed(EW'(rad_q));
    c_sum  = csx_q + csy_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.op)
            OP_POINT, OP_READ: state_d = ST_POINT;
            OP_LINE:           state_d = ST_LSET;
            OP_CIRCLE:         state_d = ST_CS0;
            OP_FILL, OP_BINARY, OP_INVERT: state_d = ST_SSET;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_POINT: begin
        px_ctl_d.wr = (op_q == OP_POINT);
        px_ctl_d.rd = (op_q == OP_READ);
        px_x_d      = xa_q;
        px_y_d      = ya_q;
        dcnt_d      = '0;
        state_d     = ST_DRAIN;
      end
      ST_LSET: begin
        lxmaj_d = l_xmaj;
        lcur_d  = l_sa;
        lend_d  = l_ea;
        lbase_d = l_sb;
        ld_d    = $unsigned(l_ea - l_sa);
        lneg_d  = l_dmin[EW-1];
        lad_d   = $unsigned(l_dmin[EW-1] ? -l_dmin : l_dmin);
        lq_d    = '0;
        lr_d    = '0;
        state_d = ST_LRUN;
      end
      ST_LRUN: begin
        px_ctl_d.wr = 1'b1;
        px_x_d      = lxmaj_q ? lcur_q : l_minor;
        px_y_d      = lxmaj_q ? l_minor : lcur_q;
        if (lcur_q == lend_q) begin
          dcnt_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          lcur_d = lcur_q + EW'(1);
          // running quotient and remainder of |dminor|*step / dmajor
          if (l_rsum >= ld_q) begin
            lr_d = l_rsum - ld_q;
            lq_d = lq_q + EW'(1);
          end else begin
            lr_d = l_rsum;
          end
        end
      end
      ST_CS0: begin
        cylo_d  = (-c_r > -ya_q) ? -c_r : -ya_q;
        cyhi_d  = (c_r < $signed(EW'(act_h)) - EW'(1) - ya_q) ? c_r :
                  $signed(EW'(act_h)) - EW'(1) - ya_q;
        cxlo_d  = (-c_r > -xa_q) ? -c_r : -xa_q;
        cxhi_d  = (c_r < $signed(EW'(act_w)) - EW'(1) - xa_q) ? c_r :
                  $signed(EW'(act_w)) - EW'(1) - xa_q;
        mul_a   = c_r;
        mul_b   = c_r;
        crr_d   = mul_p;
        state_d = ST_CS1;
      end
      ST_CS1: begin
        mul_a   = cylo_q;
        mul_b   = cylo_q;
        csy_d   = mul_p;
        state_d = ST_CS2;
      end
      ST_CS2: begin
        mul_a  = cxlo_q;
        mul_b  = cxlo_q;
        csx0_d = mul_p;
        csx_d  = mul_p;
        cx_d   = cxlo_q;
        cy_d   = cylo_q;
        if ((cylo_q > cyhi_q) || (cxlo_q > cxhi_q)) begin
          dcnt_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_CRUN;
        end
      end
      ST_CRUN: begin
        px_ctl_d.wr = (c_sum <= crr_q);
        px_x_d      = xa_q + cx_q;
        px_y_d      = ya_q + cy_q;
        if (cx_q == cxhi_q) begin
          if (cy_q == cyhi_q) begin
            dcnt_d  = '0;
            state_d = ST_DRAIN;
          end else begin
            cy_d  = cy_q + EW'(1);
            csy_d = csy_q + (SQW'(cy_q) <<< 1) + SQW'(1);
            cx_d  = cxlo_q;
            csx_d = csx0_q;
          end
        end else begin
          cx_d  = cx_q + EW'(1);
          csx_d = csx_q + (SQW'(cx_q) <<< 1) + SQW'(1);
        end
      end
      ST_SSET: begin
        mul_a = $signed(EW'(act_w));
        mul_b = $signed(EW'(act_h));
        sn_d  = NW'(mul_p);
        si_d  = '0;
        if (mul_p == '0) begin
          dcnt_d  = '0;
          state_d = ST_DRAIN;
        end else if (op_q == OP_FILL) begin
          state_d = ST_SFILL;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_SFILL: begin
        mem_we    = 1'b1;
        mem_addr  = si_q;
        mem_wdata = val_q;
        si_d      = si_q + AW'(1);
        if (NW'(si_q) == sn_q - NW'(1)) begin
          dcnt_d  = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_SRD: begin
        mem_re   = 1'b1;
        mem_addr = si_q;
        state_d  = ST_SWR;
      end
      ST_SWR: begin
        mem_we   = 1'b1;
        mem_addr = si_q;
        if (op_q == OP_BINARY) begin
          mem_wdata = (mem_rdata != '0) ? val_q : alt_q;
        end else begin
          mem_wdata = ~mem_rdata;
        end
        si_d = si_q + AW'(1);
        if (NW'(si_q) == sn_q - NW'(1)) begin
          dcnt_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_DRAIN: begin
        // wait for the pixel stage and the store to settle
        dcnt_d = dcnt_q + 2'd1;
        if (dcnt_q == 2'd2) begin
          state_d = (op_q == OP_READ) ? ST_RD_OUT : ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          ovl_d   = pp_inb ? mem_rdata : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      px_ctl_q <= '0;
      ov_q     <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      px_ctl_q <= px_ctl_d;
      ov_q     <= ov_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lxmaj_q <= lxmaj_d;
    lneg_q  <= lneg_d;
    lcur_q  <= lcur_d;
    lend_q  <= lend_d;
    lbase_q <= lbase_d;
    ld_q    <= ld_d;
    lad_q   <= lad_d;
    lq_q    <= lq_d;
    lr_q    <= lr_d;
    cylo_q  <= cylo_d;
    cyhi_q  <= cyhi_d;
    cxlo_q  <= cxlo_d;
    cxhi_q  <= cxhi_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    crr_q   <= crr_d;
    csy_q   <= csy_d;
    csx_q   <= csx_d;
    csx0_q  <= csx0_d;
    sn_q    <= sn_d;
    si_q    <= si_d;
    px_x_q  <= px_x_d;
    px_y_q  <= px_y_d;
    ovl_q   <= ovl_d;
  end

  assign rsp_o.valid      = ov_q;
  assign rsp_o.read_value = ovl_q;

  fde_pixel_pipe #(
    .EW(EW), .SW(SW), .SH(SH), .AW(AW), .PW(PIXEL_BITS)
  ) u_pixel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (px_ctl_q),
    .x_i     (px_x_q),
    .y_i     (px_y_q),
    .data_i  (val_q),
    .act_w_i (act_w),
    .act_h_i (act_h),
    .ctl_o   (pp_ctl),
    .addr_o  (pp_addr),
    .data_o  (pp_data),
    .inb_o   (pp_inb)
  );

  fde_store #(
    .DEPTH(DEPTH), .AW(AW), .PW(PIXEL_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!px_ctl_q.wr && !px_ctl_q.rd && !pp_ctl.wr && !pp_ctl.rd))
    else $error("pixel stage busy while idle");
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and write in one cycle");
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_RD_OUT))
    else $error("response raised outside read completion");
  a_line_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LRUN) |-> ((lr_q < ld_q) || (ld_q == '0)))
    else $error("line remainder out of range");
`endif
endmodule
`default_nettype wire

FILE: hdl/fde_store.sv
// Pixel store: single port memory with registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module fde_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int PW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [PW-1:0] wdata_i,
  output logic      [PW-1:0] rdata_o
);
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: hdl/fde_pixel_pipe.sv
// Pixel stage: clips a coordinate to the active frame and forms the store
// address y*width + x. Depends on fde_pkg.
`default_nettype none
module fde_pixel_pipe #(
  parameter int EW = 14,
  parameter int SW = 7,
  parameter int SH = 7,
  parameter int AW = 12,
  parameter int PW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  fde_pkg::px_ctl_t          req_i,
  input  wire logic signed [EW-1:0] x_i,
  input  wire logic signed [EW-1:0] y_i,
  input  wire logic [PW-1:0]        data_i,
  input  wire logic [SW-1:0]        act_w_i,
  input  wire logic [SH-1:0]        act_h_i,
  output fde_pkg::px_ctl_t          ctl_o,
  output logic [AW-1:0]             addr_o,
  output logic [PW-1:0]             data_o,
  output logic                      inb_o
);
  import fde_pkg::*;

  logic             in_frame;
  logic [SW+SH-1:0] lin;
  px_ctl_t          ctl_d, ctl_q;
  logic [AW-1:0]    addr_q;
  logic [PW-1:0]    data_q;
  logic             inb_q;

  always_comb begin
    in_frame = !x_i[EW-1] && (x_i[EW-2:0] < (EW-1)'(act_w_i)) &&
               !y_i[EW-1] && (y_i[EW-2:0] < (EW-1)'(act_h_i));
    lin      = y_i[SH-1:0] * act_w_i + (SW+SH)'(x_i[SW-1:0]);
    ctl_d.wr = req_i.wr && in_frame;
    ctl_d.rd = req_i.rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      inb_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (req_i.rd) begin
        inb_q <= in_frame;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(lin);
    data_q <= data_i;
  end

  assign ctl_o  = ctl_q;
  assign addr_o = addr_q;
  assign data_o = data_q;
  assign inb_o  = inb_q;
endmodule
`default_nettype wire

FILE: bench/fde_checker.sv
// Scoreboard of the draw engine: mirrors the pixel store and frame size,
// predicts read responses and compares them. Depends on fde_pkg and fde_if.
module fde_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fde_cmd_if        cmd_i,
  fde_rsp_if        rsp_i,
  fde_cfg_if        cfg_i,
  output int        fail_count_o,
  output int        pending_o
);
  import fde_pkg::*;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;

  logic [31:0] pix_mem [0:MAX_W*MAX_H-1];
  logic [CFG_DATA_W-1:0] frame_w = FRAME_SIZE_RESET;
  logic [CFG_DATA_W-1:0] frame_h = FRAME_SIZE_RESET;
  logic [31:0] read_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic longint eff_w();
    return (frame_w > MAX_W) ? MAX_W : longint'(frame_w);
  endfunction

  function automatic longint eff_h();
    return (frame_h > MAX_H) ? MAX_H : longint'(frame_h);
  endfunction

  function automatic void put_px(longint x, longint y, logic [31:0] v);
    if (x >= 0 && x < eff_w() && y >= 0 && y < eff_h()) pix_mem[y*eff_w() + x] = v;
  endfunction

  function automatic logic [31:0] get_px(longint x, longint y);
    if (x >= 0 && x < eff_w() && y >= 0 && y < eff_h()) return pix_mem[y*eff_w() + x];
    return '0;
  endfunction

  function automatic void draw_line(longint x1, longint y1, longint x2, longint y2,
                                    logic [31:0] v);
    longint dx, dy, adx, ady, t;
    dx  = x2 - x1;
    dy  = y2 - y1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (adx > ady) begin
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      for (t = x1; t <= x2; t++) put_px(t, y1 + (dy * (t - x1)) / dx, v);
    end else begin
      if (y1 > y2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      if (dy == 0) begin
        put_px(x1, y1, v);
      end else begin
        for (t = y1; t <= y2; t++) put_px(x1 + (dx * (t - y1)) / dy, t, v);
      end
    end
  endfunction

  function automatic void fill_disc(longint cx, longint cy, longint r, logic [31:0] v);
    longint ylo, yhi, xlo, xhi, x, y;
    ylo = -r; yhi = r; xlo = -r; xhi = r;
    if (ylo < -cy) ylo = -cy;
    if (yhi > eff_h() - 1 - cy) yhi = eff_h() - 1 - cy;
    if (xlo < -cx) xlo = -cx;
    if (xhi > eff_w() - 1 - cx) xhi = eff_w() - 1 - cx;
    for (y = ylo; y <= yhi; y++)
      for (x = xlo; x <= xhi; x++)
        if (x*x + y*y <= r*r) put_px(cx + x, cy + y, v);
  endfunction

  function automatic void apply_cmd();
    longint n, i;
    n = eff_w() * eff_h();
    case (cmd_i.op)
      OP_POINT:  put_px(cmd_i.x_a, cmd_i.y_a, cmd_i.value);
      OP_LINE:   draw_line(cmd_i.x_a, cmd_i.y_a, cmd_i.x_b, cmd_i.y_b, cmd_i.value);
      OP_CIRCLE: fill_disc(cmd_i.x_a, cmd_i.y_a, cmd_i.radius, cmd_i.value);
      OP_FILL:   for (i = 0; i < n; i++) pix_mem[i] = cmd_i.value;
      OP_BINARY:
        for (i = 0; i < n; i++)
          pix_mem[i] = (pix_mem[i] != 0) ? cmd_i.value : cmd_i.alt_value;
      OP_INVERT: for (i = 0; i < n; i++) pix_mem[i] = ~pix_mem[i];
      OP_READ:   read_q.push_back(get_px(cmd_i.x_a, cmd_i.y_a));
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_FRAME_WIDTH:  frame_w = cfg_i.data;
          REG_FRAME_HEIGHT: frame_h = cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) apply_cmd();
      if (rsp_i.valid && rsp_i.ready) begin
        if (read_q.size() == 0) begin
          $display("%0t: unexpected read response, expected none, actual %h",
                   $time, rsp_i.read_value);
          fail_count_o++;
        end else begin
          want = read_q.pop_front();
          if (rsp_i.read_value !== want) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want, rsp_i.read_value);
            fail_count_o++;
          end
        end
      end
      pending_o = read_q.size();
    end
  end

endmodule

FILE: bench/framebuffer_draw_engine_top_tb.sv
// Top of the draw engine bench: clock, reset, command and config stimulus,
// response back-pressure and the verdict. Depends on fde_pkg, fde_if, fde_checker.
module framebuffer_draw_engine_top_tb;
  import fde_pkg::*;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic signed [11:0]  xa, ya, xb, yb;
    logic [RADIUS_W-1:0] rad;
    logic [31:0]         val, alt;
  } draw_cmd_t;

  localparam int SETTLE_CYCLES = 2*64*64 + 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count, pending;
  bit   quiet = 1'b0;
  logic stall_req = 1'b0;
  int   cur_w = 64, cur_h = 64;

  fde_cmd_if cmd ();
  fde_rsp_if rsp ();
  fde_cfg_if cfg ();

  framebuffer_draw_engine_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  fde_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rsp_i        (rsp),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #(12 * 4_000_000);
    $display("framebuffer_draw_engine_top_tb: FAIL");
    $finish;
  end

  // Response back-pressure; a toggle of stall_req holds ready low for a long stretch.
  logic stall_seen = 1'b0;
  int   hold_cnt = 0;
  initial rsp.ready = 1'b0;
  always @(posedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_cnt   <= 400;
      rsp.ready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  task automatic send_cmd(draw_cmd_t c);
    if (!quiet && $urandom_range(99) < 11) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd.op        <= c.op;
    cmd.x_a       <= c.xa;
    cmd.y_a       <= c.ya;
    cmd.x_b       <= c.xb;
    cmd.y_b       <= c.yb;
    cmd.radius    <= c.rad;
    cmd.value     <= c.val;
    cmd.alt_value <= c.alt;
    cmd.valid     <= 1'b1;
    do @(posedge clk_i); while (!cmd.ready);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last transfer.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.index <= idx;
    cfg.data  <= data;
    cfg.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  // Drain, let any draw finish, resize, then fill so every live entry is written.
  task automatic resize(int w, int h, logic [31:0] fill_val);
    draw_cmd_t c;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
    cfg.valid <= 1'b0;
    cur_w = (w > 64) ? 64 : w;
    cur_h = (h > 64) ? 64 : h;
    c = '{op: OP_FILL, xa: 0, ya: 0, xb: 0, yb: 0, rad: 0, val: fill_val, alt: 0};
    send_cmd(c);
  endtask

  function automatic logic signed [11:0] rand_coord(int lim);
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) return 12'(int'($urandom_range(0, lim + 7)) - 4);
    if (pick < 95) return 12'(int'($urandom_range(0, 200)) - 100);
    return 12'($urandom);
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int pick;
    pick  = $urandom_range(99);
    c.xa  = rand_coord(cur_w);
    c.ya  = rand_coord(cur_h);
    c.xb  = rand_coord(cur_w);
    c.yb  = rand_coord(cur_h);
    c.rad = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    c.val = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    c.alt = $urandom;
    if (pick < 25)      c.op = OP_POINT;
    else if (pick < 50) c.op = OP_LINE;
    else if (pick < 63) c.op = OP_CIRCLE;
    else if (pick < 93) c.op = OP_READ;
    else if (pick < 95) c.op = OP_FILL;
    else if (pick < 97) c.op = OP_BINARY;
    else if (pick < 99) c.op = OP_INVERT;
    else                c.op = OP_UNUSED;
    return c;
  endfunction

  function automatic draw_cmd_t mk(logic [OP_W-1:0] op, int xa, int ya, int xb, int yb,
                                   int rad, logic [31:0] val, logic [31:0] alt);
    draw_cmd_t c;
    c = '{op: op, xa: 12'(xa), ya: 12'(ya), xb: 12'(xb), yb: 12'(yb),
          rad: 8'(rad), val: val, alt: alt};
    return c;
  endfunction

  int sizes_w [8] = '{1, 8, 0, 100, 13, 64, 20, 127};
  int sizes_h [8] = '{1, 5, 9, 3, 64, 1, 100, 127};

  initial begin
    draw_cmd_t dir_q [$];
    rst_ni        = 1'b0;
    cmd.valid     = 1'b0;
    cmd.op        = OP_POINT;
    cmd.x_a       = '0;
    cmd.y_a       = '0;
    cmd.x_b       = '0;
    cmd.y_b       = '0;
    cmd.radius    = '0;
    cmd.value     = '0;
    cmd.alt_value = '0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_FRAME_WIDTH;
    cfg.data      = FRAME_SIZE_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, clipping, line orientations, disc extremes, whole-frame ops.
    dir_q = '{
      mk(OP_FILL, 0, 0, 0, 0, 0, 32'h0, 0),
      mk(OP_POINT, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0),
      mk(OP_POINT, 63, 63, 0, 0, 0, 32'h1234_5678, 0),
      mk(OP_POINT, -1, 5, 0, 0, 0, 32'hDEAD_BEEF, 0),
      mk(OP_POINT, 2047, -2048, 0, 0, 0, 32'h1, 0),
      mk(OP_LINE, 40, 3, 10, 3, 0, 32'hA5A5_A5A5, 0),
      mk(OP_LINE, 7, 50, 7, 20, 0, 32'h5A5A_5A5A, 0),
      mk(OP_LINE, 30, 30, 30, 30, 0, 32'h77, 0),
      mk(OP_LINE, 5, 60, 25, 2, 0, 32'h88, 0),
      mk(OP_LINE, 60, 10, 2, 25, 0, 32'h99, 0),
      mk(OP_LINE, 0, 0, 20, 20, 0, 32'hAA, 0),
      mk(OP_LINE, -2048, -2048, 2047, 2047, 0, 32'hBB, 0),
      mk(OP_CIRCLE, 32, 32, 0, 0, 0, 32'hCC, 0),
      mk(OP_CIRCLE, -3, 62, 0, 0, 6, 32'hDD, 0),
      mk(OP_READ, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_READ, 63, 63, 0, 0, 0, 0, 0),
      mk(OP_READ, 64, 0, 0, 0, 0, 0, 0),
      mk(OP_READ, -2048, 2047, 0, 0, 0, 0, 0),
      mk(OP_BINARY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0),
      mk(OP_READ, 5, 5, 0, 0, 0, 0, 0),
      mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_UNUSED, 1, 1, 2, 2, 3, 32'h5, 32'h6),
      mk(OP_CIRCLE, 20, 20, 0, 0, 255, 32'hEE, 0),
      mk(OP_READ, 20, 20, 0, 0, 0, 0, 0),
      mk(OP_READ, 0, 63, 0, 0, 0, 0, 0)
    };
    foreach (dir_q[i]) send_cmd(dir_q[i]);

    for (int ph = 0; ph < 8; ph++) begin
      resize(sizes_w[ph], sizes_h[ph], $urandom);
      for (int k = 0; k < 236; k++) begin
        if (ph == 3) quiet = (k < 150);
        if (ph == 2 && k == 100) begin
          // Long response stall while reads keep coming.
          stall_req <= ~stall_req;
          for (int j = 0; j < 40; j++)
            send_cmd(mk(OP_READ, $urandom_range(0, 9), $urandom_range(0, 9), 0, 0, 0, 0, 0));
        end
        if (ph == 4 && k == 120) wait_drained();
        send_cmd(rand_cmd());
      end
      quiet = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("framebuffer_draw_engine_top_tb: PASS");
    end else begin
      $display("framebuffer_draw_engine_top_tb: FAIL");
    end
    $finish;
  end

endmodule
